>>> rtl/imusbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imusbc_pkg
// Shared widths, register indexes, reset values, result codes and word types
// for the IMU static bias calibrator.
// ----------------------------------------------------------------------------
package imusbc_pkg;

   localparam int NORM_FRAC_BITS   = 4;
   localparam int OFFSET_FRAC_BITS = 8;

   localparam int AXIS_W      = 16;
   localparam int COUNT_W     = 16;
   localparam int NORM_W      = 20;
   localparam int OFFSET_W    = 24;
   localparam int OFF_LIMIT_W = 23;
   localparam int SQ_SUM_W    = 2 * AXIS_W;
   localparam int RADICAND_W  = SQ_SUM_W + 2 * NORM_FRAC_BITS;
   localparam int NORM_SUM_W  = 36;
   localparam int RATE_SUM_W  = 33;
   localparam int DIV_W       = (RATE_SUM_W + OFFSET_FRAC_BITS > NORM_SUM_W) ?
                                (RATE_SUM_W + OFFSET_FRAC_BITS) : NORM_SUM_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;

   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_COUNT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NORM_SPREAD_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GYRO_SPREAD_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_NORM_TARGET       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NORM_TOLERANCE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GYRO_OFFSET_LIMIT = 3'd5;

   localparam logic [COUNT_W-1:0]     RST_SAMPLE_COUNT      = 16'd6000;
   localparam logic [NORM_W-1:0]      RST_NORM_SPREAD_LIMIT = 20'd8912;
   localparam logic [AXIS_W-1:0]      RST_GYRO_SPREAD_LIMIT = 16'd141;
   localparam logic [NORM_W-1:0]      RST_NORM_TARGET       = 20'd174720;
   localparam logic [NORM_W-1:0]      RST_NORM_TOLERANCE    = 20'd8912;
   localparam logic [OFF_LIMIT_W-1:0] RST_GYRO_OFFSET_LIMIT = 23'd2403;

   localparam logic [1:0] CAUSE_NONE   = 2'd0;
   localparam logic [1:0] CAUSE_SPREAD = 2'd1;
   localparam logic [1:0] CAUSE_NORM   = 2'd2;
   localparam logic [1:0] CAUSE_OFFSET = 2'd3;

   localparam logic [NORM_W-1:0]   NORM_CAP    = '1;
   localparam logic [OFFSET_W-1:0] OFF_POS_CAP = {1'b0, {(OFFSET_W-1){1'b1}}};
   localparam logic [OFFSET_W-1:0] OFF_NEG_CAP = {1'b1, {(OFFSET_W-1){1'b0}}};

   typedef struct packed {
      logic signed [AXIS_W-1:0] acc_x;
      logic signed [AXIS_W-1:0] acc_y;
      logic signed [AXIS_W-1:0] acc_z;
      logic signed [AXIS_W-1:0] rate_x;
      logic signed [AXIS_W-1:0] rate_y;
      logic signed [AXIS_W-1:0] rate_z;
   } req_word_type;

   typedef struct packed {
      logic                       passed;
      logic [1:0]                 fail_cause;
      logic [NORM_W-1:0]          mean_norm;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic signed [OFFSET_W-1:0] offset_z;
      logic [COUNT_W-1:0]         samples_used;
   } rsp_word_type;

endpackage

>>> rtl/imusbc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imusbc_sqrt
// Bit-pair integer square root, one result bit per cycle, saturated to the
// norm width.
// ----------------------------------------------------------------------------
module imusbc_sqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [imusbc_pkg::RADICAND_W-1:0]    radicand,
   output logic                                 done,
   output logic [imusbc_pkg::NORM_W-1:0]        root
);

   localparam int W = imusbc_pkg::RADICAND_W;
   localparam logic [W-1:0] BIT_TOP = {2'b01, {(W-2){1'b0}}};

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] root_ff, root_in;
   logic [W-1:0] bit_ff, bit_in;
   logic [W:0]   trial;
   logic         take;

   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      take    = ({1'b0, rem_ff} >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         root_in = '0;
         bit_in  = BIT_TOP;
      end else if (busy_ff) begin
         if (take) begin
            rem_in  = rem_ff - trial[W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = (root_ff[W-1:imusbc_pkg::NORM_W] != '0) ? imusbc_pkg::NORM_CAP :
                 root_ff[imusbc_pkg::NORM_W-1:0];

endmodule

>>> rtl/imusbc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imusbc_div
// Restoring unsigned divider, one quotient bit per cycle; divisor is a
// sample count and never zero.
// ----------------------------------------------------------------------------
module imusbc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [imusbc_pkg::DIV_W-1:0]      dividend,
   input  logic [imusbc_pkg::COUNT_W-1:0]    divisor,
   output logic                              done,
   output logic [imusbc_pkg::DIV_W-1:0]      quotient
);

   localparam int W     = imusbc_pkg::DIV_W;
   localparam int DW    = imusbc_pkg::COUNT_W;
   localparam int CNT_W = $clog2(W + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             ge;

   always_comb begin
      trial    = {rem_ff, quo_ff[W-1]};
      diff     = trial - {1'b0, dvs_ff};
      ge       = (trial >= {1'b0, dvs_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dvs_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in   = {quo_ff[W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/imu_static_bias_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_static_bias_calibrator
// Averages acceleration norm and gyro rates over one attempt, watches their
// spread, and reports mean norm, gyro offsets and a pass/fail verdict.
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+------------------------------
//  req     | in  | req_valid/req_stall | req_word_type  (6 raw axes)
//  rsp     | out | rsp_valid/rsp_stall | rsp_word_type  (verdict, means)
//  csr     | in  | csr_valid/csr_ready | csr_index, csr_data
//
//  A sample takes three squarings on one multiplier, then 20 steps of the
//  root unit. A sample that closes an attempt without a spread failure adds
//  four runs of the 41-step divider. req_stall is high from acceptance until
//  the sample is done; a finished word waits in the output register while the
//  next sample is taken. Synchronous reset, no clearing pass; csr writes are
//  always accepted.
// ----------------------------------------------------------------------------
module imu_static_bias_calibrator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  imusbc_pkg::req_word_type               req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output imusbc_pkg::rsp_word_type               rsp_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [imusbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [imusbc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW  = imusbc_pkg::AXIS_W;
   localparam int NW  = imusbc_pkg::NORM_W;
   localparam int OW  = imusbc_pkg::OFFSET_W;
   localparam int CW  = imusbc_pkg::COUNT_W;
   localparam int RSW = imusbc_pkg::RATE_SUM_W;
   localparam int NSW = imusbc_pkg::NORM_SUM_W;
   localparam int DW  = imusbc_pkg::DIV_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_ROOT   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_DIV_GO = 3'd5;
   localparam logic [2:0] ST_DIVIDE = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   // configuration
   logic [CW-1:0]                          sample_count_ff, sample_count_in;
   logic [NW-1:0]                          norm_spread_limit_ff, norm_spread_limit_in;
   logic [AW-1:0]                          gyro_spread_limit_ff, gyro_spread_limit_in;
   logic [NW-1:0]                          norm_target_ff, norm_target_in;
   logic [NW-1:0]                          norm_tolerance_ff, norm_tolerance_in;
   logic [imusbc_pkg::OFF_LIMIT_W-1:0]     gyro_offset_limit_ff, gyro_offset_limit_in;

   // sequencer and working registers
   logic [2:0]                             state_ff, state_in;
   imusbc_pkg::req_word_type               smp_ff, smp_in;
   logic [1:0]                             axis_ff, axis_in;
   logic [imusbc_pkg::SQ_SUM_W-1:0]        sq_sum_ff, sq_sum_in;
   logic [NW-1:0]                          norm_ff, norm_in;
   logic [1:0]                             div_sel_ff, div_sel_in;
   logic                                   spread_bad_ff, spread_bad_in;
   logic                                   off_bad_ff, off_bad_in;
   logic [NW-1:0]                          mean_ff, mean_in;
   logic signed [OW-1:0]                   offset_ff [3];
   logic signed [OW-1:0]                   offset_in [3];

   // attempt state
   logic [CW-1:0]                          sample_index_ff, sample_index_in;
   logic [NSW-1:0]                         norm_sum_ff, norm_sum_in;
   logic signed [RSW-1:0]                  rate_sum_ff [3];
   logic signed [RSW-1:0]                  rate_sum_in [3];
   logic [NW-1:0]                          norm_max_ff, norm_max_in;
   logic [NW-1:0]                          norm_min_ff, norm_min_in;
   logic signed [AW-1:0]                   rate_max_ff [3];
   logic signed [AW-1:0]                   rate_max_in [3];
   logic signed [AW-1:0]                   rate_min_ff [3];
   logic signed [AW-1:0]                   rate_min_in [3];

   // output register
   logic                                   rsp_valid_ff, rsp_valid_in;
   imusbc_pkg::rsp_word_type               rsp_word_ff, rsp_word_in;

   // root and divider units
   logic                                   sqrt_start, sqrt_done;
   logic [imusbc_pkg::RADICAND_W-1:0]      radicand;
   logic [NW-1:0]                          sqrt_root;
   logic                                   div_start, div_done;
   logic [DW-1:0]                          dividend, quotient;

   // combinational helpers
   logic signed [AW-1:0]                   acc_op;
   logic signed [2*AW-1:0]                 product;
   logic signed [AW-1:0]                   rate_smp [3];
   logic                                   first;
   logic [NW-1:0]                          norm_spread;
   logic [AW:0]                            rate_spread [3];
   logic                                   spread_hit;
   logic [CW-1:0]                          target_n;
   logic [1:0]                             rs_idx;
   logic signed [RSW-1:0]                  rs_sel;
   logic                                   rs_neg;
   logic [RSW-1:0]                         rs_mag;
   logic [OW-1:0]                          mag_cap;
   logic [OW-1:0]                          mag_sat;
   logic [NW-1:0]                          dev;
   logic [1:0]                             cause;
   logic                                   out_free;

   imusbc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   imusbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (sample_index_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // configuration writes
   always_comb begin
      sample_count_in      = sample_count_ff;
      norm_spread_limit_in = norm_spread_limit_ff;
      gyro_spread_limit_in = gyro_spread_limit_ff;
      norm_target_in       = norm_target_ff;
      norm_tolerance_in    = norm_tolerance_ff;
      gyro_offset_limit_in = gyro_offset_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            imusbc_pkg::REG_SAMPLE_COUNT:      sample_count_in      = csr_data[CW-1:0];
            imusbc_pkg::REG_NORM_SPREAD_LIMIT: norm_spread_limit_in = csr_data[NW-1:0];
            imusbc_pkg::REG_GYRO_SPREAD_LIMIT: gyro_spread_limit_in = csr_data[AW-1:0];
            imusbc_pkg::REG_NORM_TARGET:       norm_target_in       = csr_data[NW-1:0];
            imusbc_pkg::REG_NORM_TOLERANCE:    norm_tolerance_in    = csr_data[NW-1:0];
            imusbc_pkg::REG_GYRO_OFFSET_LIMIT:
               gyro_offset_limit_in = csr_data[imusbc_pkg::OFF_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath helpers
   always_comb begin
      rate_smp[0] = smp_ff.rate_x;
      rate_smp[1] = smp_ff.rate_y;
      rate_smp[2] = smp_ff.rate_z;

      unique case (axis_ff)
         2'd0:    acc_op = smp_ff.acc_x;
         2'd1:    acc_op = smp_ff.acc_y;
         default: acc_op = smp_ff.acc_z;
      endcase
      product  = acc_op * acc_op;
      radicand = imusbc_pkg::RADICAND_W'(sq_sum_ff) << (2 * imusbc_pkg::NORM_FRAC_BITS);

      first       = (sample_index_ff == '0);
      norm_spread = norm_max_ff - norm_min_ff;
      spread_hit  = (norm_spread > norm_spread_limit_ff);
      for (int i = 0; i < 3; i++) begin
         rate_spread[i] = {rate_max_ff[i][AW-1], rate_max_ff[i]} -
                          {rate_min_ff[i][AW-1], rate_min_ff[i]};
         if (rate_spread[i] > {1'b0, gyro_spread_limit_ff}) spread_hit = 1'b1;
      end
      target_n = (sample_count_ff == '0) ? CW'(1) : sample_count_ff;

      rs_idx   = (div_sel_ff == 2'd0) ? 2'd0 : (div_sel_ff - 2'd1);
      rs_sel   = rate_sum_ff[rs_idx];
      rs_neg   = rs_sel[RSW-1];
      rs_mag   = rs_neg ? RSW'(-rs_sel) : RSW'(rs_sel);
      dividend = (div_sel_ff == 2'd0) ? DW'(norm_sum_ff) :
                 (DW'(rs_mag) << imusbc_pkg::OFFSET_FRAC_BITS);
      mag_cap  = rs_neg ? imusbc_pkg::OFF_NEG_CAP : imusbc_pkg::OFF_POS_CAP;
      mag_sat  = (quotient > DW'(mag_cap)) ? mag_cap : quotient[OW-1:0];

      dev = (mean_ff >= norm_target_ff) ? (mean_ff - norm_target_ff) :
                                          (norm_target_ff - mean_ff);
      priority if (spread_bad_ff)              cause = imusbc_pkg::CAUSE_SPREAD;
      else if (dev > norm_tolerance_ff)        cause = imusbc_pkg::CAUSE_NORM;
      else if (off_bad_ff)                     cause = imusbc_pkg::CAUSE_OFFSET;
      else                                     cause = imusbc_pkg::CAUSE_NONE;

      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      smp_in          = smp_ff;
      axis_in         = axis_ff;
      sq_sum_in       = sq_sum_ff;
      norm_in         = norm_ff;
      div_sel_in      = div_sel_ff;
      spread_bad_in   = spread_bad_ff;
      off_bad_in      = off_bad_ff;
      mean_in         = mean_ff;
      sample_index_in = sample_index_ff;
      norm_sum_in     = norm_sum_ff;
      norm_max_in     = norm_max_ff;
      norm_min_in     = norm_min_ff;
      for (int i = 0; i < 3; i++) begin
         offset_in[i]   = offset_ff[i];
         rate_sum_in[i] = rate_sum_ff[i];
         rate_max_in[i] = rate_max_ff[i];
         rate_min_in[i] = rate_min_ff[i];
      end
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               smp_in    = req_word;
               axis_in   = 2'd0;
               sq_sum_in = '0;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (axis_ff == 2'd3) begin
               sqrt_start = 1'b1;
               state_in   = ST_ROOT;
            end else begin
               sq_sum_in = sq_sum_ff + $unsigned(product);
               axis_in   = axis_ff + 2'd1;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               norm_in  = sqrt_root;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            norm_sum_in = norm_sum_ff + NSW'(norm_ff);
            if (first || norm_ff > norm_max_ff) norm_max_in = norm_ff;
            if (first || norm_ff < norm_min_ff) norm_min_in = norm_ff;
            for (int i = 0; i < 3; i++) begin
               rate_sum_in[i] = rate_sum_ff[i] + RSW'(rate_smp[i]);
               if (first || rate_smp[i] > rate_max_ff[i]) rate_max_in[i] = rate_smp[i];
               if (first || rate_smp[i] < rate_min_ff[i]) rate_min_in[i] = rate_smp[i];
            end
            sample_index_in = sample_index_ff + 1'b1;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            off_bad_in = 1'b0;
            div_sel_in = 2'd0;
            if (spread_hit) begin
               spread_bad_in = 1'b1;
               state_in      = ST_RESULT;
            end else if (sample_index_ff >= target_n) begin
               state_in = ST_DIV_GO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (div_sel_ff == 2'd0) begin
                  mean_in = (quotient[DW-1:NW] != '0) ? imusbc_pkg::NORM_CAP :
                            quotient[NW-1:0];
               end else begin
                  offset_in[rs_idx] = rs_neg ? -$signed(mag_sat) : $signed(mag_sat);
                  if (mag_sat > OW'(gyro_offset_limit_ff)) off_bad_in = 1'b1;
               end
               if (div_sel_ff == 2'd3) begin
                  state_in = ST_RESULT;
               end else begin
                  div_sel_in = div_sel_ff + 2'd1;
                  state_in   = ST_DIV_GO;
               end
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.passed       = (cause == imusbc_pkg::CAUSE_NONE);
               rsp_word_in.fail_cause   = cause;
               rsp_word_in.samples_used = sample_index_ff;
               if (spread_bad_ff) begin
                  rsp_word_in.mean_norm = '0;
                  rsp_word_in.offset_x  = '0;
                  rsp_word_in.offset_y  = '0;
                  rsp_word_in.offset_z  = '0;
               end else begin
                  rsp_word_in.mean_norm = mean_ff;
                  rsp_word_in.offset_x  = offset_ff[0];
                  rsp_word_in.offset_y  = offset_ff[1];
                  rsp_word_in.offset_z  = offset_ff[2];
               end
               // new attempt
               spread_bad_in   = 1'b0;
               sample_index_in = '0;
               norm_sum_in     = '0;
               norm_max_in     = '0;
               norm_min_in     = '0;
               for (int i = 0; i < 3; i++) begin
                  rate_sum_in[i] = '0;
                  rate_max_in[i] = '0;
                  rate_min_in[i] = '0;
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff      <= imusbc_pkg::RST_SAMPLE_COUNT;
         norm_spread_limit_ff <= imusbc_pkg::RST_NORM_SPREAD_LIMIT;
         gyro_spread_limit_ff <= imusbc_pkg::RST_GYRO_SPREAD_LIMIT;
         norm_target_ff       <= imusbc_pkg::RST_NORM_TARGET;
         norm_tolerance_ff    <= imusbc_pkg::RST_NORM_TOLERANCE;
         gyro_offset_limit_ff <= imusbc_pkg::RST_GYRO_OFFSET_LIMIT;
         state_ff             <= ST_IDLE;
         spread_bad_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         sample_index_ff      <= '0;
         norm_sum_ff          <= '0;
         norm_max_ff          <= '0;
         norm_min_ff          <= '0;
         for (int i = 0; i < 3; i++) begin
            rate_sum_ff[i] <= '0;
            rate_max_ff[i] <= '0;
            rate_min_ff[i] <= '0;
         end
      end else begin
         sample_count_ff      <= sample_count_in;
         norm_spread_limit_ff <= norm_spread_limit_in;
         gyro_spread_limit_ff <= gyro_spread_limit_in;
         norm_target_ff       <= norm_target_in;
         norm_tolerance_ff    <= norm_tolerance_in;
         gyro_offset_limit_ff <= gyro_offset_limit_in;
         state_ff             <= state_in;
         spread_bad_ff        <= spread_bad_in;
         rsp_valid_ff         <= rsp_valid_in;
         sample_index_ff      <= sample_index_in;
         norm_sum_ff          <= norm_sum_in;
         norm_max_ff          <= norm_max_in;
         norm_min_ff          <= norm_min_in;
         for (int i = 0; i < 3; i++) begin
            rate_sum_ff[i] <= rate_sum_in[i];
            rate_max_ff[i] <= rate_max_in[i];
            rate_min_ff[i] <= rate_min_in[i];
         end
      end
      smp_ff      <= smp_in;
      axis_ff     <= axis_in;
      sq_sum_ff   <= sq_sum_in;
      norm_ff     <= norm_in;
      div_sel_ff  <= div_sel_in;
      off_bad_ff  <= off_bad_in;
      mean_ff     <= mean_in;
      rsp_word_ff <= rsp_word_in;
      for (int i = 0; i < 3; i++) begin
         offset_ff[i] <= offset_in[i];
      end
   end

endmodule

>>> test/imusbc_calib_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imusbc_calib_checker
// Watches the sample, verdict and register channels of the bias calibrator.
// Keeps its own copy of the registers and the attempt state, and works out
// the verdict word owed by each accepted sample that closes an attempt. Every verdict
// word the block delivers is compared field by field with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module imusbc_calib_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  imusbc_pkg::req_word_type           req_word,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  imusbc_pkg::rsp_word_type           rsp_word,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [imusbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [imusbc_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                 fail_count,
   output int                                 pending
);
   import imusbc_pkg::*;

   logic [COUNT_W-1:0]     set_sample_count;
   logic [NORM_W-1:0]      set_norm_spread;
   logic [AXIS_W-1:0]      set_gyro_spread;
   logic [NORM_W-1:0]      set_norm_target;
   logic [NORM_W-1:0]      set_norm_tol;
   logic [OFF_LIMIT_W-1:0] set_offset_limit;

   logic [COUNT_W-1:0]     taken;
   longint                 norm_total;
   longint                 rate_total [3];
   logic [NORM_W-1:0]      norm_peak;
   logic [NORM_W-1:0]      norm_floor;
   int                     rate_peak [3];
   int                     rate_floor [3];

   rsp_word_type           expected_verdicts [$];
   rsp_word_type           want;

   // floor of the root, built bit by bit from the top
   function automatic logic [NORM_W-1:0] accel_norm(input int x, input int y, input int z);
      longint radicand;
      longint root;
      longint trial;
      radicand = (longint'(x) * x + longint'(y) * y + longint'(z) * z) << (2 * NORM_FRAC_BITS);
      root = 0;
      for (int b = 23; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= radicand) root = trial;
      end
      return (root > longint'(NORM_CAP)) ? NORM_CAP : root[NORM_W-1:0];
   endfunction

   // truncates toward zero, saturates to the signed offset range
   function automatic longint mean_rate_offset(input longint total, input logic [COUNT_W-1:0] n);
      longint mag;
      bit     neg;
      neg = total < 0;
      mag = neg ? -total : total;
      mag = (mag << OFFSET_FRAC_BITS) / longint'(n);
      if (neg) return (mag > longint'(OFF_NEG_CAP)) ? -longint'(OFF_NEG_CAP) : -mag;
      return (mag > longint'(OFF_POS_CAP)) ? longint'(OFF_POS_CAP) : mag;
   endfunction

   task automatic restart_attempt();
      taken = '0;
      norm_total = 0;
      norm_peak = '0;
      norm_floor = '0;
      for (int i = 0; i < 3; i++) begin
         rate_total[i] = 0;
         rate_peak[i] = 0;
         rate_floor[i] = 0;
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_SAMPLE_COUNT:      set_sample_count = data[COUNT_W-1:0];
         REG_NORM_SPREAD_LIMIT: set_norm_spread = data[NORM_W-1:0];
         REG_GYRO_SPREAD_LIMIT: set_gyro_spread = data[AXIS_W-1:0];
         REG_NORM_TARGET:       set_norm_target = data[NORM_W-1:0];
         REG_NORM_TOLERANCE:    set_norm_tol = data[NORM_W-1:0];
         REG_GYRO_OFFSET_LIMIT: set_offset_limit = data[OFF_LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic absorb_sample(input req_word_type w);
      int                 acc [3];
      int                 rate [3];
      logic [NORM_W-1:0]  nv;
      logic [COUNT_W-1:0] used;
      logic [COUNT_W-1:0] goal;
      bit                 spread_bad;
      rsp_word_type       v;
      longint             mean_full;
      longint             dev;
      longint             off [3];
      longint             mag;
      acc[0] = $signed(w.acc_x);
      acc[1] = $signed(w.acc_y);
      acc[2] = $signed(w.acc_z);
      rate[0] = $signed(w.rate_x);
      rate[1] = $signed(w.rate_y);
      rate[2] = $signed(w.rate_z);
      nv = accel_norm(acc[0], acc[1], acc[2]);
      norm_total += longint'(nv);
      for (int i = 0; i < 3; i++) rate_total[i] += rate[i];
      if (taken == '0) begin
         norm_peak = nv;
         norm_floor = nv;
         for (int i = 0; i < 3; i++) begin
            rate_peak[i] = rate[i];
            rate_floor[i] = rate[i];
         end
      end else begin
         if (nv > norm_peak) norm_peak = nv;
         if (nv < norm_floor) norm_floor = nv;
         for (int i = 0; i < 3; i++) begin
            if (rate[i] > rate_peak[i]) rate_peak[i] = rate[i];
            if (rate[i] < rate_floor[i]) rate_floor[i] = rate[i];
         end
      end
      taken = taken + 1'b1;
      used = taken;

      spread_bad = (norm_peak - norm_floor) > set_norm_spread;
      for (int i = 0; i < 3; i++)
         if (rate_peak[i] - rate_floor[i] > int'(set_gyro_spread)) spread_bad = 1'b1;

      v = '0;
      v.samples_used = used;
      goal = (set_sample_count == '0) ? COUNT_W'(1) : set_sample_count;
      if (spread_bad) begin
         v.fail_cause = CAUSE_SPREAD;
         expected_verdicts.push_back(v);
         restart_attempt();
      end else if (used != '0 && used >= goal) begin
         mean_full = norm_total / longint'(used);
         dev = mean_full - longint'(set_norm_target);
         if (dev < 0) dev = -dev;
         for (int i = 0; i < 3; i++) off[i] = mean_rate_offset(rate_total[i], used);
         v.fail_cause = CAUSE_NONE;
         if (dev > longint'(set_norm_tol)) begin
            v.fail_cause = CAUSE_NORM;
         end else begin
            for (int i = 0; i < 3; i++) begin
               mag = (off[i] < 0) ? -off[i] : off[i];
               if (mag > longint'(set_offset_limit)) v.fail_cause = CAUSE_OFFSET;
            end
         end
         v.passed = (v.fail_cause == CAUSE_NONE);
         v.mean_norm = (mean_full > longint'(NORM_CAP)) ? NORM_CAP : mean_full[NORM_W-1:0];
         v.offset_x = off[0][OFFSET_W-1:0];
         v.offset_y = off[1][OFFSET_W-1:0];
         v.offset_z = off[2][OFFSET_W-1:0];
         expected_verdicts.push_back(v);
         restart_attempt();
      end
   endtask

   task automatic note_mismatch(input string field, input logic signed [63:0] expected_val,
                                input logic signed [63:0] actual_val);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected_val,
               actual_val);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_sample_count = RST_SAMPLE_COUNT;
         set_norm_spread = RST_NORM_SPREAD_LIMIT;
         set_gyro_spread = RST_GYRO_SPREAD_LIMIT;
         set_norm_target = RST_NORM_TARGET;
         set_norm_tol = RST_NORM_TOLERANCE;
         set_offset_limit = RST_GYRO_OFFSET_LIMIT;
         restart_attempt();
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) write_register(csr_index, csr_data);
         if (req_valid && !req_stall) absorb_sample(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: verdict word with none owed, got %h", $time, rsp_word);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_word.passed !== want.passed)
                  note_mismatch("passed", want.passed, rsp_word.passed);
               if (rsp_word.fail_cause !== want.fail_cause)
                  note_mismatch("fail_cause", want.fail_cause, rsp_word.fail_cause);
               if (rsp_word.mean_norm !== want.mean_norm)
                  note_mismatch("mean_norm", want.mean_norm, rsp_word.mean_norm);
               if (rsp_word.offset_x !== want.offset_x)
                  note_mismatch("offset_x", want.offset_x, rsp_word.offset_x);
               if (rsp_word.offset_y !== want.offset_y)
                  note_mismatch("offset_y", want.offset_y, rsp_word.offset_y);
               if (rsp_word.offset_z !== want.offset_z)
                  note_mismatch("offset_z", want.offset_z, rsp_word.offset_z);
               if (rsp_word.samples_used !== want.samples_used)
                  note_mismatch("samples_used", want.samples_used, rsp_word.samples_used);
            end
         end
      end
      pending = expected_verdicts.size();
   end

endmodule

>>> test/tb_imu_static_bias_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_static_bias_calibrator
// Drives the bias calibrator with a short directed set (field extremes, each
// verdict code, zero and lowered sample counts, spread failing on the closing
// sample) and then phases of mostly still sample streams with jitter, drift
// and noise under varied register settings. Both sides idle at random; one
// phase runs without idling and one holds the verdict side off for a long
// stretch. Prediction and comparison sit in imusbc_calib_checker.
// ----------------------------------------------------------------------------
module tb_imu_static_bias_calibrator;
   import imusbc_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 1500;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 127;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_SAMPLE_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatch_total;
   int verdicts_owed;
   int cycle_count = 0;
   bit steady = 1'b0;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int          bx, by, bz, rbx, rby, rbz, acc_j, rate_j, roll;
   int unsigned sc, nsl, gsl, tgt, tol, offl;
   real         base_norm;
   req_word_type noise_word;

   imu_static_bias_calibrator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   imusbc_calib_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (mismatch_total),
      .pending    (verdicts_owed)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // verdict side: random stalls, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = !steady && ($urandom_range(99) < 8);
      end
   end

   function automatic logic [AXIS_W-1:0] to_axis(input int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[AXIS_W-1:0];
   endfunction

   function automatic int wobble(input int j);
      return int'($urandom_range(2 * j)) - j;
   endfunction

   task automatic send_sample(input req_word_type w);
      while (!steady && $urandom_range(99) < 8) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_axes(input int ax, input int ay, input int az,
                            input int rx, input int ry, input int rz);
      req_word_type w;
      w.acc_x = to_axis(ax);
      w.acc_y = to_axis(ay);
      w.acc_z = to_axis(az);
      w.rate_x = to_axis(rx);
      w.rate_y = to_axis(ry);
      w.rate_z = to_axis(rz);
      send_sample(w);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = CSR_DATA_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int unsigned count, input int unsigned nspread,
                                 input int unsigned gspread, input int unsigned target,
                                 input int unsigned tolerance, input int unsigned off_limit);
      csr_write(REG_SAMPLE_COUNT, count);
      csr_write(REG_NORM_SPREAD_LIMIT, nspread);
      csr_write(REG_GYRO_SPREAD_LIMIT, gspread);
      csr_write(REG_NORM_TARGET, target);
      csr_write(REG_NORM_TOLERANCE, tolerance);
      csr_write(REG_GYRO_OFFSET_LIMIT, off_limit);
      csr_valid = 1'b0;
   endtask

   // a sample that closes no attempt owes no word but may still be in flight
   task automatic drain_and_settle();
      req_valid = 1'b0;
      while (verdicts_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one sample per attempt, loose limits: field extremes and offsets at the ends of their range
      apply_settings(1, 20'hFFFFF, 16'hFFFF, 0, 20'hFFFFF, 23'h7FFFFF);
      send_axes(0, 0, 0, 0, 0, 0);
      send_axes(32767, 32767, 32767, 32767, 32767, 32767);
      send_axes(-32768, -32768, -32768, -32768, -32768, -32768);
      send_axes(21845, -21846, 21845, -21846, 21845, -21846);
      drain_and_settle();
      // zero count behaves as one
      csr_write(REG_SAMPLE_COUNT, 0);
      csr_valid = 1'b0;
      send_axes(100, -200, 300, 5, -6, 7);
      send_axes(-1, -1, -1, -1, -1, -1);
      drain_and_settle();

      // three-sample attempts around a 1 g target
      apply_settings(3, 2000, 20, 262144, 1000, 1280);
      send_axes(0, 0, 16384, 3, -2, 1);
      send_axes(0, 0, 16384, 4, -2, 1);
      send_axes(0, 0, 16384, 3, -1, 0);
      repeat (3) send_axes(0, 0, 16500, 0, 0, 0);
      repeat (3) send_axes(0, 0, 16384, 10, 0, 0);
      send_axes(0, 0, 16384, 0, 0, 0);
      send_axes(0, 0, 16384, 0, 30, 0);
      send_axes(0, 0, 16384, 0, 0, 0);
      send_axes(0, 0, 16384, 0, 0, 0);
      send_axes(0, 0, 16600, 0, 0, 0);
      drain_and_settle();

      // count lowered part way through an attempt
      apply_settings(6, 20'hFFFFF, 16'hFFFF, 0, 20'hFFFFF, 23'h7FFFFF);
      send_axes(10, 20, 30, 1, 2, 3);
      send_axes(11, 21, 31, 2, 3, 4);
      send_axes(12, 22, 32, 3, 4, 5);
      drain_and_settle();
      csr_write(REG_SAMPLE_COUNT, 2);
      csr_valid = 1'b0;
      send_axes(13, 23, 33, 4, 5, 6);
      drain_and_settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 5) begin
            bx = -32768;
            by = -32768;
            bz = -32768;
         end else begin
            bx = int'($urandom_range(40000)) - 20000;
            by = int'($urandom_range(40000)) - 20000;
            bz = int'($urandom_range(40000)) - 20000;
         end
         if (phase == 7) begin
            rbx = int'($urandom_range(65535)) - 32768;
            rby = int'($urandom_range(65535)) - 32768;
            rbz = int'($urandom_range(65535)) - 32768;
         end else begin
            rbx = int'($urandom_range(200)) - 100;
            rby = int'($urandom_range(200)) - 100;
            rbz = int'($urandom_range(200)) - 100;
         end
         case ($urandom_range(3))
            0: acc_j = 0;
            1: acc_j = 2;
            2: acc_j = 8;
            default: acc_j = 40;
         endcase
         case ($urandom_range(3))
            0: rate_j = 0;
            1: rate_j = 1;
            2: rate_j = 3;
            default: rate_j = 10;
         endcase

         roll = $urandom_range(99);
         if (roll < 70) sc = $urandom_range(12, 2);
         else if (roll < 85) sc = $urandom_range(60, 13);
         else sc = 1;
         case ($urandom_range(3))
            0: nsl = 0;
            1: nsl = $urandom_range(1500);
            2: nsl = $urandom_range(20'hFFFFF);
            default: nsl = 20'hFFFFF;
         endcase
         case ($urandom_range(3))
            0: gsl = 0;
            1: gsl = $urandom_range(25);
            2: gsl = $urandom_range(16'hFFFF);
            default: gsl = 16'hFFFF;
         endcase
         base_norm = $sqrt(real'(bx) * bx + real'(by) * by + real'(bz) * bz) * 16.0;
         if ($urandom_range(3) != 0) tgt = $rtoi(base_norm);
         else tgt = $urandom_range(20'hFFFFF);
         if (tgt > 20'hFFFFF) tgt = 20'hFFFFF;
         case ($urandom_range(3))
            0: tol = 0;
            1: tol = $urandom_range(200);
            2: tol = $urandom_range(20000);
            default: tol = 20'hFFFFF;
         endcase
         case ($urandom_range(3))
            0: offl = 0;
            1: offl = $urandom_range(30000);
            2: offl = $urandom_range(23'h7FFFFF);
            default: offl = 23'h7FFFFF;
         endcase
         if (phase == 0) begin
            sc = 16'hFFFF;
            nsl = 20'hFFFFF;
            gsl = 16'hFFFF;
            tgt = 20'hFFFFF;
            tol = 20'hFFFFF;
            offl = 23'h7FFFFF;
         end else if (phase == 1) begin
            sc = 0;
            nsl = 0;
            gsl = 0;
            tgt = 0;
            tol = 0;
            offl = 0;
         end else if (phase == 4) begin
            sc = 1;
         end

         steady = (phase == 3);
         apply_settings(sc, nsl, gsl, tgt, tol, offl);
         if (phase == 4) hold_request++;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
               noise_word = {$urandom(), $urandom(), $urandom()};
               send_sample(noise_word);
            end else begin
               if (roll < 10) bz = bz + int'($urandom_range(600)) - 300;
               send_axes(bx + wobble(acc_j), by + wobble(acc_j), bz + wobble(acc_j),
                         rbx + wobble(rate_j), rby + wobble(rate_j), rbz + wobble(rate_j));
            end
         end
         drain_and_settle();
      end

      steady = 1'b0;
      if (mismatch_total == 0 && verdicts_owed == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
